// ===== design/pptp_pkg.sv =====
// Shared types and constants for the preemptive priority task picker.
package pptp_pkg;

	// Ready queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int SCAN_W      = IDX_W + 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Field widths
	localparam int ID_W    = 16;
	localparam int PRIO_W  = 16;
	localparam int STAMP_W = 32;
	localparam int QCNT_W  = 5;

	// Item kinds
	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_DECIDE = 1'b1;

	// Decision codes
	typedef enum logic [1:0] {
		DEC_NONE    = 2'd0,
		DEC_ASSIGN  = 2'd1,
		DEC_PREEMPT = 2'd2
	} dec_t;

	// Input item
	typedef struct packed {
		logic              kind;
		logic [ID_W-1:0]   task_id;
		logic [PRIO_W-1:0] task_priority;
		logic              running_valid;
		logic [ID_W-1:0]   running_id;
		logic [PRIO_W-1:0] running_priority;
	} req_item_t;

	// Result item
	typedef struct packed {
		logic [1:0]        decision;
		logic [ID_W-1:0]   assign_id;
		logic [ID_W-1:0]   resign_id;
		logic              queue_full_drop;
		logic [QCNT_W-1:0] queue_count;
	} rsp_item_t;

	// One queue slot
	typedef struct packed {
		logic [ID_W-1:0]    task_id;
		logic [PRIO_W-1:0]  prio;
		logic [STAMP_W-1:0] stamp;
	} slot_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic add;
		logic scan;
		logic decide;
		logic push;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_done;
	} stat_t;

endpackage

// ===== design/pptp_if.sv =====
// Valid/ready channel interfaces for request and result items.
interface pptp_req_if import pptp_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface pptp_rsp_if import pptp_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

// ===== design/preemptive_priority_task_picker.sv =====
// Top level of the preemptive priority task picker.
//
//   channel  dir  handshake          payload
//   req      in   req.valid/ready    kind, task_id, task_priority, running_*
//   rsp      out  rsp.valid/ready    decision, assign_id, resign_id, drop, count
//
// An add item is latched on acceptance, handled in the add step, then pushed to the
// output register. A decide item is scanned by the single read port, one slot per
// cycle; the read and compare stage drains, then a pick step and a push step follow.
// One item is in work at a time; a new item is accepted while the previous
// result waits in the output register. A stalled rsp holds the block in its
// final step. Reset empties the queue and clears the arrival stamp at once.
module preemptive_priority_task_picker import pptp_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	pptp_req_if.sink    req,
	pptp_rsp_if.source  rsp
);

	cmd_t  cmd;
	stat_t stat;

	// Sequencer
	pptp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_kind   (req.item.kind),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Queue storage and compare logic
	pptp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_item  (req.item),
		.out_item (rsp.item)
	);

endmodule

// ===== design/pptp_ctrl.sv =====
// Task picker sequencing state machine: accept, add or scan then pick, result push.
module pptp_ctrl import pptp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_kind,
	output logic  in_ready,
	input  logic  out_ready,
	output logic  out_valid,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ADD  = 5'b00010,
		S_SCAN = 5'b00100,
		S_PICK = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	// Handshakes and commands
	always_comb begin
		in_ready   = (state_q == S_IDLE);
		accept     = in_valid && in_ready;
		cmd.load   = accept;
		cmd.add    = (state_q == S_ADD);
		cmd.scan   = (state_q == S_SCAN);
		cmd.decide = (state_q == S_PICK);
		cmd.push   = (state_q == S_DONE) && (!out_valid_q || out_ready);
	end

	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (in_kind == KIND_DECIDE) ? S_SCAN : S_ADD;
				end
			end
			S_ADD:  state_d = S_DONE;
			S_SCAN: begin
				if (stat.scan_done) begin
					state_d = S_PICK;
				end
			end
			S_PICK: state_d = S_DONE;
			S_DONE: begin
				if (cmd.push) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/pptp_dp.sv =====
// Datapath: slot memory, valid bits, urgency scan, add/decide update, result registers.
module pptp_dp import pptp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	output stat_t     stat,
	input  req_item_t in_item,
	output rsp_item_t out_item
);

	// Slot memory and occupancy
	slot_t                mem [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]     count_q;
	logic [STAMP_W-1:0]   next_stamp_q;

	// Latched item and result staging
	req_item_t itm_q;
	rsp_item_t res_q;
	rsp_item_t out_q;

	// Scan pipeline
	logic [SCAN_W-1:0] scan_cnt_q;
	logic              pend_s1;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	slot_t             rd_s1;
	logic              best_found_q;
	slot_t             best_q;
	logic [IDX_W-1:0]  best_idx_q;

	logic              full;
	logic [IDX_W-1:0]  free_idx;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_idx;
	logic              better;
	dec_t              dec;
	logic [ID_W-1:0]   assign_id;
	logic [ID_W-1:0]   resign_id;
	logic              preempt;
	logic              take;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	slot_t             mem_wd;
	logic [CNT_W-1:0]  count_d;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));

	// Lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	// Scan read address and compare
	assign rd_en  = cmd.scan && (scan_cnt_q != SCAN_W'(QUEUE_DEPTH));
	assign rd_idx = scan_cnt_q[IDX_W-1:0];
	assign stat.scan_done = (scan_cnt_q == SCAN_W'(QUEUE_DEPTH)) && !pend_s1;

	// Strictly more urgent keeps the earlier slot on a full tie
	assign better = !best_found_q || (rd_s1.prio < best_q.prio) ||
		((rd_s1.prio == best_q.prio) && (rd_s1.stamp < best_q.stamp));

	// Decision on the scanned top task
	always_comb begin
		dec       = DEC_NONE;
		assign_id = '0;
		resign_id = '0;
		preempt   = 1'b0;
		take      = 1'b0;
		if (best_found_q) begin
			assign_id = best_q.task_id;
			if (itm_q.running_valid) begin
				if (itm_q.running_priority > best_q.prio) begin
					dec       = DEC_PREEMPT;
					resign_id = itm_q.running_id;
					preempt   = 1'b1;
				end
			end else begin
				dec  = DEC_ASSIGN;
				take = 1'b1;
			end
		end
	end

	// Memory write port: add into free slot or reinsert preempted task
	always_comb begin
		mem_we = (cmd.add && !full) || (cmd.decide && preempt);
		if (cmd.add) begin
			mem_wa = free_idx;
			mem_wd = '{task_id: itm_q.task_id, prio: itm_q.task_priority,
				stamp: next_stamp_q};
		end else begin
			mem_wa = best_idx_q;
			mem_wd = '{task_id: itm_q.running_id, prio: itm_q.running_priority,
				stamp: '0};
		end
	end

	// Queue count after the item
	always_comb begin
		count_d = count_q;
		if (cmd.add && !full) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.decide && take) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	// Slot memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_s1 <= mem[rd_idx];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			count_q      <= '0;
			next_stamp_q <= '0;
			scan_cnt_q   <= '0;
			pend_s1      <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			count_q <= count_d;
			pend_s1 <= rd_en;
			if (cmd.load) begin
				scan_cnt_q   <= '0;
				best_found_q <= 1'b0;
			end else begin
				if (rd_en) begin
					scan_cnt_q <= scan_cnt_q + SCAN_W'(1);
				end
				if (pend_s1 && vld_s1 && better) begin
					best_found_q <= 1'b1;
				end
			end
			if (cmd.add && !full) begin
				valid_q[free_idx] <= 1'b1;
				next_stamp_q      <= next_stamp_q + STAMP_W'(1);
			end
			if (cmd.decide && take) begin
				valid_q[best_idx_q] <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			itm_q <= in_item;
		end
		if (rd_en) begin
			vld_s1 <= valid_q[rd_idx];
			idx_s1 <= rd_idx;
		end
		if (pend_s1 && vld_s1 && better) begin
			best_q     <= rd_s1;
			best_idx_q <= idx_s1;
		end
		if (cmd.add) begin
			res_q.decision        <= DEC_NONE;
			res_q.assign_id       <= '0;
			res_q.resign_id       <= '0;
			res_q.queue_full_drop <= full;
			res_q.queue_count     <= QCNT_W'(count_d);
		end else if (cmd.decide) begin
			res_q.decision        <= dec;
			res_q.assign_id       <= assign_id;
			res_q.resign_id       <= resign_id;
			res_q.queue_full_drop <= 1'b0;
			res_q.queue_count     <= QCNT_W'(count_d);
		end
		if (cmd.push) begin
			out_q <= res_q;
		end
	end

	assign out_item = out_q;

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the task picker: tracks the ready queue and checks every decision.
`timescale 1ns / 1ps

module tb_top import pptp_pkg::*; ();

	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AT      = 150;
	localparam int PAUSE_AT     = 200;

	// Receiver stall patterns
	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_MOSTLY,
		RX_PERIODIC
	} rx_mode_t;

	// Ready queue tracker: holds its own copy of the slots and the owed decisions
	class ready_queue_mirror;
		bit                 slot_used[QUEUE_DEPTH];
		bit [ID_W-1:0]      slot_id[QUEUE_DEPTH];
		bit [PRIO_W-1:0]    slot_prio[QUEUE_DEPTH];
		bit [STAMP_W-1:0]   slot_stamp[QUEUE_DEPTH];
		bit [STAMP_W-1:0]   stamp_next;
		rsp_item_t          decisions_owed[$];
		int                 errors;
		int                 results_seen;

		function int owed();
			return decisions_owed.size();
		endfunction

		// Most urgent slot: lowest priority value, then smallest stamp, then lowest index
		function int most_urgent();
			int best;
			best = -1;
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (slot_used[i]) begin
					if (best < 0 || slot_prio[i] < slot_prio[best] ||
					    (slot_prio[i] == slot_prio[best] && slot_stamp[i] < slot_stamp[best]))
						best = i;
				end
			end
			return best;
		endfunction

		// Apply one accepted item and queue the decision it owes
		function void take_request(req_item_t it);
			rsp_item_t want;
			int        slot;
			int        n;
			want = '0;
			slot = -1;
			if (it.kind == KIND_ADD) begin
				for (int i = 0; i < QUEUE_DEPTH; i++)
					if (!slot_used[i] && slot < 0)
						slot = i;
				if (slot < 0) begin
					want.queue_full_drop = 1'b1;
				end else begin
					slot_used[slot]  = 1'b1;
					slot_id[slot]    = it.task_id;
					slot_prio[slot]  = it.task_priority;
					slot_stamp[slot] = stamp_next;
					stamp_next       = stamp_next + STAMP_W'(1);
				end
			end else begin
				slot = most_urgent();
				if (slot >= 0) begin
					want.assign_id = slot_id[slot];
					if (!it.running_valid) begin
						want.decision   = DEC_ASSIGN;
						slot_used[slot] = 1'b0;
					end else if (it.running_priority > slot_prio[slot]) begin
						// preempted task takes the freed slot with stamp zero
						want.decision    = DEC_PREEMPT;
						want.resign_id   = it.running_id;
						slot_id[slot]    = it.running_id;
						slot_prio[slot]  = it.running_priority;
						slot_stamp[slot] = '0;
					end else begin
						want.decision = DEC_NONE;
					end
				end
			end
			n = 0;
			for (int i = 0; i < QUEUE_DEPTH; i++)
				n += int'(slot_used[i]);
			want.queue_count = n[QCNT_W-1:0];
			decisions_owed.push_back(want);
		endfunction

		task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("[%0t] MISMATCH result %0d %s: got %0h want %0h",
				$time, results_seen, what, got, want);
			errors++;
		endtask

		// Compare one accepted result with the oldest owed decision
		task match_decision(rsp_item_t got);
			rsp_item_t want;
			if (decisions_owed.size() == 0) begin
				flag_mismatch("unexpected result", {30'd0, got.decision}, '0);
				return;
			end
			want = decisions_owed.pop_front();
			results_seen++;
			if (got.decision !== want.decision)
				flag_mismatch("decision", 32'(got.decision), 32'(want.decision));
			if (got.assign_id !== want.assign_id)
				flag_mismatch("assign_id", 32'(got.assign_id), 32'(want.assign_id));
			if (got.resign_id !== want.resign_id)
				flag_mismatch("resign_id", 32'(got.resign_id), 32'(want.resign_id));
			if (got.queue_full_drop !== want.queue_full_drop)
				flag_mismatch("queue_full_drop", 32'(got.queue_full_drop),
					32'(want.queue_full_drop));
			if (got.queue_count !== want.queue_count)
				flag_mismatch("queue_count", 32'(got.queue_count), 32'(want.queue_count));
		endtask
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic hold_rsp = 1'b0;
	int   sent_total = 0;
	int   quiet_cycles = 0;

	ready_queue_mirror mirror = new();

	pptp_req_if req_ch ();
	pptp_rsp_if rsp_ch ();

	preemptive_priority_task_picker u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Item builders; fields the item kind ignores get random bits
	function automatic req_item_t mk_add(logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
		req_item_t it;
		it.kind             = KIND_ADD;
		it.task_id          = id;
		it.task_priority    = prio;
		it.running_valid    = 1'($urandom_range(0, 1));
		it.running_id       = ID_W'($urandom);
		it.running_priority = PRIO_W'($urandom);
		return it;
	endfunction

	function automatic req_item_t mk_decide(logic rv, logic [ID_W-1:0] rid,
		logic [PRIO_W-1:0] rprio);
		req_item_t it;
		it.kind             = KIND_DECIDE;
		it.task_id          = ID_W'($urandom);
		it.task_priority    = PRIO_W'($urandom);
		it.running_valid    = rv;
		it.running_id       = rid;
		it.running_priority = rprio;
		return it;
	endfunction

	task automatic send_item(req_item_t it);
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.item  = it;
		do @(posedge clk); while (!req_ch.ready);
		sent_total++;
	endtask

	task automatic idle_for(int cycles);
		if (cycles == 0)
			return;
		@(negedge clk);
		req_ch.valid = 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Sender pause until every owed decision has come back
	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (mirror.owed() != 0)
			@(negedge clk);
	endtask

	task automatic run_directed();
		// empty queue, with and without a running task
		send_item(mk_decide(1'b0, ID_W'($urandom), PRIO_W'($urandom)));
		send_item(mk_decide(1'b1, 16'hFFFF, 16'h0000));
		// fill the queue: extremes first, then a few tied priorities
		send_item(mk_add(16'h0000, 16'hFFFF));
		send_item(mk_add(16'hFFFF, 16'h0000));
		for (int i = 2; i < QUEUE_DEPTH; i++)
			send_item(mk_add(ID_W'($urandom), PRIO_W'(3 + (i % 3))));
		// full queue drops the add
		send_item(mk_add(16'h1234, 16'h0000));
		// running equal to top: no change
		send_item(mk_decide(1'b1, ID_W'($urandom), 16'h0000));
		// running less urgent: preempt while full
		send_item(mk_decide(1'b1, 16'hA5A5, 16'h0001));
		// no running task: assign and remove
		send_item(mk_decide(1'b0, ID_W'($urandom), PRIO_W'($urandom)));
		// running more urgent than top: no change
		send_item(mk_decide(1'b1, ID_W'($urandom), 16'h0002));
		// preempt by the least urgent value, ties it with the oldest stamp
		send_item(mk_decide(1'b1, 16'h5A5A, 16'hFFFF));
		send_item(mk_add(ID_W'($urandom), 16'h0003));
	endtask

	// Random phases: add-heavy, balanced, drain-heavy; mostly narrow priorities
	task automatic run_random();
		int  random_sent;
		int  phase_len;
		int  add_pct;
		int  burst;
		bit  narrow;
		bit  paused;
		random_sent = 0;
		paused      = 1'b0;
		while (random_sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0:       add_pct = 80;
				1:       add_pct = 50;
				default: add_pct = 25;
			endcase
			narrow = ($urandom_range(0, 3) != 0);
			while (phase_len > 0 && random_sent < RANDOM_ITEMS) begin
				burst = $urandom_range(1, 24);
				while (burst > 0 && phase_len > 0 && random_sent < RANDOM_ITEMS) begin
					if ($urandom_range(0, 99) < add_pct)
						send_item(mk_add(ID_W'($urandom),
							narrow ? 16'($urandom_range(0, 7)) : 16'($urandom)));
					else
						send_item(mk_decide($urandom_range(0, 3) != 0, ID_W'($urandom),
							narrow ? 16'($urandom_range(0, 8)) : 16'($urandom)));
					burst--;
					phase_len--;
					random_sent++;
				end
				idle_for(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
			end
			if (!paused && random_sent >= PAUSE_AT) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	// Stimulus and end of run
	initial begin
		req_ch.valid = 1'b0;
		req_ch.item  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_directed();
		wait_drained();
		run_random();
		wait_drained();
		repeat (2 * QUEUE_DEPTH + 8) @(negedge clk);
		if (mirror.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Receiver: stretches of different stall patterns, overridden by the long hold
	initial begin
		rx_mode_t mode;
		int       stretch;
		int       period;
		int       low_n;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode    = rx_mode_t'($urandom_range(0, 3));
			stretch = $urandom_range(30, 200);
			period  = $urandom_range(2, 7);
			low_n   = $urandom_range(1, period - 1);
			for (int c = 0; c < stretch; c++) begin
				@(negedge clk);
				if (hold_rsp)
					rsp_ch.ready = 1'b0;
				else case (mode)
					RX_OPEN:   rsp_ch.ready = 1'b1;
					RX_COIN:   rsp_ch.ready = 1'($urandom_range(0, 1));
					RX_MOSTLY: rsp_ch.ready = ($urandom_range(0, 3) != 0);
					default:   rsp_ch.ready = ((c % period) >= low_n);
				endcase
			end
		end
	end

	// Long receiver hold while the sender keeps offering items
	initial begin
		wait (sent_total >= HOLD_AT);
		@(negedge clk);
		hold_rsp = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_rsp = 1'b0;
	end

	// Handshake monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				mirror.take_request(req_ch.item);
			if (rsp_ch.valid && rsp_ch.ready)
				mirror.match_decision(rsp_ch.item);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// Watchdog on cycles without any handshake
	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(negedge clk);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== preemptive_priority_task_picker.f =====
design/pptp_pkg.sv
design/pptp_if.sv
design/pptp_ctrl.sv
design/pptp_dp.sv
design/preemptive_priority_task_picker.sv
verif/tb_top.sv
